@@ src/dbps_pkg.sv @@
package dbps_pkg;

   localparam int COUNT_BITS = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_START_PRICE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIKE_PRICE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_BARRIER  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_BARRIER  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIFT_PER_STEP = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VOL_PER_STEP   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIRS_PER_PATH = 3'd6;

   localparam logic [32:0] COUNT_MAX = 33'((64'd1 << COUNT_BITS) - 64'd1);

   localparam logic [32:0] ONE_Q30     = 33'h0_4000_0000;
   localparam logic [31:0] MAX32       = 32'hFFFF_FFFF;
   localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0] LOG2E_Q30   = 31'd1549082005;
   localparam logic [29:0] LN2_Q30     = 30'd744261118;

   localparam int LOG_ROUNDS  = 28;
   localparam int SQRT_ROUNDS = 32;
   localparam int SIN_TERMS   = 10;
   localparam int EXP_TERMS   = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [35:0] RCP_NUM = 36'hF_FFFF_FFFF;

   localparam logic [8:0] SIN_DIV [SIN_TERMS] = '{
      9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342, 9'd420};
   localparam logic [8:0] COS_DIV [SIN_TERMS] = '{
      9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306, 9'd380};
   localparam logic [8:0] EXP_DIV [EXP_TERMS] = '{
      9'd1, 9'd2, 9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8,
      9'd9, 9'd10, 9'd11, 9'd12, 9'd13, 9'd14, 9'd15, 9'd16};

   localparam logic [35:0] SIN_RCP [SIN_TERMS] = '{
      RCP_NUM / 36'd6,   RCP_NUM / 36'd20,  RCP_NUM / 36'd42,  RCP_NUM / 36'd72,
      RCP_NUM / 36'd110, RCP_NUM / 36'd156, RCP_NUM / 36'd210, RCP_NUM / 36'd272,
      RCP_NUM / 36'd342, RCP_NUM / 36'd420};
   localparam logic [35:0] COS_RCP [SIN_TERMS] = '{
      RCP_NUM / 36'd2,   RCP_NUM / 36'd12,  RCP_NUM / 36'd30,  RCP_NUM / 36'd56,
      RCP_NUM / 36'd90,  RCP_NUM / 36'd132, RCP_NUM / 36'd182, RCP_NUM / 36'd240,
      RCP_NUM / 36'd306, RCP_NUM / 36'd380};
   localparam logic [35:0] EXP_RCP [EXP_TERMS] = '{
      RCP_NUM / 36'd1,  RCP_NUM / 36'd2,  RCP_NUM / 36'd3,  RCP_NUM / 36'd4,
      RCP_NUM / 36'd5,  RCP_NUM / 36'd6,  RCP_NUM / 36'd7,  RCP_NUM / 36'd8,
      RCP_NUM / 36'd9,  RCP_NUM / 36'd10, RCP_NUM / 36'd11, RCP_NUM / 36'd12,
      RCP_NUM / 36'd13, RCP_NUM / 36'd14, RCP_NUM / 36'd15, RCP_NUM / 36'd16};

   typedef logic signed [32:0] norm_type;

   typedef struct packed {
      norm_type n0;
      norm_type n1;
   } pair_type;

   typedef struct packed {
      logic        start;
      logic [32:0] t;
      logic [31:0] m;
      logic [8:0]  d;
      logic [35:0] rcp;
   } term_req_type;

   typedef struct packed {
      logic [31:0] start_price;
      logic [31:0] strike_price;
      logic [31:0] upper_barrier;
      logic [31:0] lower_barrier;
      logic [31:0] drift_per_step;
      logic [30:0] vol_per_step;
      logic [15:0] pairs_per_path;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      start_price:    32'd6553600,
      strike_price:   32'd5898240,
      upper_barrier:  32'd10485760,
      lower_barrier:  32'd4915200,
      drift_per_step: 32'hFFFF_F9B5,
      vol_per_step:   31'd3037000,
      pairs_per_path: 16'd5000};

endpackage

@@ src/dbps_req_if.sv @@
interface dbps_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] uniform_a;
   logic [31:0] uniform_b;

   modport source (output valid, output uniform_a, output uniform_b, input ready);
   modport sink (input valid, input uniform_a, input uniform_b, output ready);
endinterface

@@ src/dbps_rsp_if.sv @@
interface dbps_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] payoff;
   logic        knocked_out;
   logic [31:0] final_price;

   modport source (output valid, output payoff, output knocked_out, output final_price,
                   input ready);
   modport sink (input valid, input payoff, input knocked_out, input final_price,
                 output ready);
endinterface

@@ src/dbps_term.sv @@
module dbps_term import dbps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  term_req_type req,
   output logic [34:0]  quot,
   output logic         done
);

   logic        v1_ff, v2_ff, v3_ff;
   logic [34:0] p1_ff, p2_ff;
   logic [8:0]  d1_ff, d2_ff;
   logic [35:0] rcp_ff;
   logic [34:0] q_ff;
   logic [34:0] quot_ff;

   logic [64:0] prod;
   logic [70:0] qprod;
   logic [43:0] qd;
   logic [43:0] rem;
   logic [34:0] quot_in;

   always_comb begin
      prod  = 65'(req.t) * 65'(req.m);
      qprod = 71'(p1_ff) * 71'(rcp_ff);
      qd    = 44'(q_ff) * 44'(d2_ff);
      rem   = 44'(p2_ff) - qd;
      if (rem >= 44'(d2_ff)) begin
         quot_in = q_ff + 35'd1;
      end else begin
         quot_in = q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= req.start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      p1_ff   <= prod[64:30];
      d1_ff   <= req.d;
      rcp_ff  <= req.rcp;
      q_ff    <= qprod[70:36];
      p2_ff   <= p1_ff;
      d2_ff   <= d1_ff;
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;
   assign done = v3_ff;

endmodule

@@ src/dbps_queue.sv @@
module dbps_queue import dbps_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  pair_type push_data,
   output logic     full,
   input  logic     pop,
   output pair_type pop_data,
   output logic     not_empty
);

   pair_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QPTR_W:0]     count_ff, count_in;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ff];

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("Word pushed into a full queue.");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> not_empty)
      else $error("Word popped from an empty queue.");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
      else $error("Queue count beyond its depth.");
`endif

endmodule

@@ src/dbps_front.sv @@
module dbps_front import dbps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   dbps_req_if.sink   req_ch,
   output pair_type   pair,
   output logic       push,
   input  logic       full
);

   localparam logic [3:0] F_IDLE  = 4'd0;
   localparam logic [3:0] F_NORM  = 4'd1;
   localparam logic [3:0] F_LOG   = 4'd2;
   localparam logic [3:0] F_Y     = 4'd3;
   localparam logic [3:0] F_SQRT  = 4'd4;
   localparam logic [3:0] F_ANG   = 4'd5;
   localparam logic [3:0] F_A2    = 4'd6;
   localparam logic [3:0] F_TERM  = 4'd7;
   localparam logic [3:0] F_TWAIT = 4'd8;
   localparam logic [3:0] F_SCALE = 4'd9;
   localparam logic [3:0] F_PUSH  = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic [31:0]        ua_ff, ua_in;
   logic [31:0]        ub_ff, ub_in;
   logic [31:0]        m_ff, m_in;
   logic [5:0]         ex_ff, ex_in;
   logic [27:0]        frac_ff, frac_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [63:0]        v_ff, v_in;
   logic [63:0]        res_ff, res_in;
   logic [30:0]        a_ff, a_in;
   logic [31:0]        a2_ff, a2_in;
   logic [32:0]        ts_ff, ts_in;
   logic [32:0]        tc_ff, tc_in;
   logic signed [33:0] sn_ff, sn_in;
   logic signed [33:0] cs_ff, cs_in;
   logic [3:0]         k_ff, k_in;
   pair_type           pair_ff, pair_in;

   logic [4:0]         lead;
   logic [63:0]        sq;
   logic [33:0]        lmag;
   logic [64:0]        yprod;
   logic [63:0]        bitv;
   logic [63:0]        trial;
   logic [60:0]        aprod;
   logic [61:0]        a2prod;
   logic signed [33:0] s_v, c_v;
   logic [33:0]        s_abs, c_abs;
   logic [64:0]        s_prod, c_prod;
   logic [32:0]        s_mag, c_mag;
   term_req_type       sreq, creq;
   logic [34:0]        qs, qc;
   logic               done_s, done_c;

   dbps_term u_sin_term (
      .clock (clock),
      .reset (reset),
      .req   (sreq),
      .quot  (qs),
      .done  (done_s)
   );

   dbps_term u_cos_term (
      .clock (clock),
      .reset (reset),
      .req   (creq),
      .quot  (qc),
      .done  (done_c)
   );

   always_comb begin
      lead = '0;
      for (int i = 0; i < 32; i++) begin
         if (ua_ff[i]) begin
            lead = 5'(i);
         end
      end
   end

   always_comb begin
      sq     = 64'(m_ff) * 64'(m_ff);
      lmag   = {ex_ff, 28'b0} - {6'b0, frac_ff};
      yprod  = 65'(lmag) * 65'(TWO_LN2_Q30);
      bitv   = 64'd1 << {cnt_ff, 1'b0};
      trial  = res_ff + bitv;
      aprod  = 61'(ub_ff[29:0]) * 61'(HALF_PI_Q30);
      a2prod = 62'(a_ff) * 62'(a_ff);

      case (ub_ff[31:30])
         2'd0: begin
            s_v = sn_ff;
            c_v = cs_ff;
         end
         2'd1: begin
            s_v = cs_ff;
            c_v = -sn_ff;
         end
         2'd2: begin
            s_v = -sn_ff;
            c_v = -cs_ff;
         end
         default: begin
            s_v = -cs_ff;
            c_v = sn_ff;
         end
      endcase
      s_abs  = s_v[33] ? 34'(-s_v) : 34'(s_v);
      c_abs  = c_v[33] ? 34'(-c_v) : 34'(c_v);
      s_prod = 65'(res_ff[31:0]) * 65'(s_abs[32:0]);
      c_prod = 65'(res_ff[31:0]) * 65'(c_abs[32:0]);
      s_mag  = {1'b0, s_prod[61:30]};
      c_mag  = {1'b0, c_prod[61:30]};

      sreq.start = (state_ff == F_TERM);
      sreq.t     = ts_ff;
      sreq.m     = a2_ff;
      sreq.d     = SIN_DIV[k_ff];
      sreq.rcp   = SIN_RCP[k_ff];
      creq.start = (state_ff == F_TERM);
      creq.t     = tc_ff;
      creq.m     = a2_ff;
      creq.d     = COS_DIV[k_ff];
      creq.rcp   = COS_RCP[k_ff];
   end

   always_comb begin
      state_in = state_ff;
      ua_in    = ua_ff;
      ub_in    = ub_ff;
      m_in     = m_ff;
      ex_in    = ex_ff;
      frac_in  = frac_ff;
      cnt_in   = cnt_ff;
      v_in     = v_ff;
      res_in   = res_ff;
      a_in     = a_ff;
      a2_in    = a2_ff;
      ts_in    = ts_ff;
      tc_in    = tc_ff;
      sn_in    = sn_ff;
      cs_in    = cs_ff;
      k_in     = k_ff;
      pair_in  = pair_ff;
      push     = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (req_ch.valid) begin
               ua_in    = (req_ch.uniform_a == '0) ? 32'd1 : req_ch.uniform_a;
               ub_in    = req_ch.uniform_b;
               state_in = F_NORM;
            end
         end
         F_NORM: begin
            m_in     = ua_ff << (5'd31 - lead);
            ex_in    = 6'd32 - 6'(lead);
            frac_in  = '0;
            cnt_in   = '0;
            state_in = F_LOG;
         end
         F_LOG: begin
            if (sq[63]) begin
               m_in    = sq[63:32];
               frac_in = {frac_ff[26:0], 1'b1};
            end else begin
               m_in    = sq[62:31];
               frac_in = {frac_ff[26:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(LOG_ROUNDS - 1)) begin
               state_in = F_Y;
            end
         end
         F_Y: begin
            v_in     = {2'b0, yprod[63:30], 28'b0};
            res_in   = '0;
            cnt_in   = 5'(SQRT_ROUNDS - 1);
            state_in = F_SQRT;
         end
         F_SQRT: begin
            if (v_ff >= trial) begin
               v_in   = v_ff - trial;
               res_in = (res_ff >> 1) + bitv;
            end else begin
               res_in = res_ff >> 1;
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               state_in = F_ANG;
            end
         end
         F_ANG: begin
            a_in     = aprod[60:30];
            state_in = F_A2;
         end
         F_A2: begin
            a2_in    = a2prod[61:30];
            ts_in    = 33'(a_ff);
            tc_in    = ONE_Q30;
            sn_in    = signed'(34'(a_ff));
            cs_in    = signed'(34'(ONE_Q30));
            k_in     = '0;
            state_in = F_TERM;
         end
         F_TERM: begin
            state_in = F_TWAIT;
         end
         F_TWAIT: begin
            if (done_s && done_c) begin
               ts_in = qs[32:0];
               tc_in = qc[32:0];
               if (!k_ff[0]) begin
                  sn_in = sn_ff - signed'({1'b0, qs[32:0]});
                  cs_in = cs_ff - signed'({1'b0, qc[32:0]});
               end else begin
                  sn_in = sn_ff + signed'({1'b0, qs[32:0]});
                  cs_in = cs_ff + signed'({1'b0, qc[32:0]});
               end
               if (k_ff == 4'(SIN_TERMS - 1)) begin
                  state_in = F_SCALE;
               end else begin
                  k_in     = k_ff + 4'd1;
                  state_in = F_TERM;
               end
            end
         end
         F_SCALE: begin
            pair_in.n0 = s_v[33] ? -signed'(s_mag) : signed'(s_mag);
            pair_in.n1 = c_v[33] ? -signed'(c_mag) : signed'(c_mag);
            state_in   = F_PUSH;
         end
         F_PUSH: begin
            if (!full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ua_ff   <= ua_in;
      ub_ff   <= ub_in;
      m_ff    <= m_in;
      ex_ff   <= ex_in;
      frac_ff <= frac_in;
      cnt_ff  <= cnt_in;
      v_ff    <= v_in;
      res_ff  <= res_in;
      a_ff    <= a_in;
      a2_ff   <= a2_in;
      ts_ff   <= ts_in;
      tc_ff   <= tc_in;
      sn_ff   <= sn_in;
      cs_ff   <= cs_in;
      k_ff    <= k_in;
      pair_ff <= pair_in;
   end

   assign req_ch.ready = (state_ff == F_IDLE);
   assign pair         = pair_ff;

endmodule

@@ src/dbps_back.sv @@
module dbps_back import dbps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  pair_type   pair,
   input  logic       pair_valid,
   output logic       pop,
   dbps_rsp_if.source rsp_ch
);

   localparam logic [3:0] B_IDLE  = 4'd0;
   localparam logic [3:0] B_VN    = 4'd1;
   localparam logic [3:0] B_X     = 4'd2;
   localparam logic [3:0] B_G     = 4'd3;
   localparam logic [3:0] B_ETERM = 4'd4;
   localparam logic [3:0] B_EWAIT = 4'd5;
   localparam logic [3:0] B_MUL   = 4'd6;
   localparam logic [3:0] B_SHIFT = 4'd7;
   localparam logic [3:0] B_END   = 4'd8;

   logic [3:0]            state_ff, state_in;
   norm_type              norm_ff, norm_in;
   norm_type              n1_ff, n1_in;
   logic                  second_ff, second_in;
   logic [31:0]           price_ff, price_in;
   logic                  knock_ff, knock_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [34:0]           vn_ff, vn_in;
   logic                  nneg_ff, nneg_in;
   logic                  xneg_ff, xneg_in;
   logic [37:0]           zm_ff, zm_in;
   logic [9:0]            k_ff, k_in;
   logic [29:0]           g_ff, g_in;
   logic [32:0]           term_ff, term_in;
   logic [31:0]           sum_ff, sum_in;
   logic [3:0]            ek_ff, ek_in;
   logic [33:0]           p_ff, p_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           payoff_ff, payoff_in;
   logic                  ko_ff, ko_in;
   logic [31:0]           final_ff, final_in;

   logic [32:0]           nabs;
   logic [62:0]           vprod;
   logic [36:0]           drift_ext;
   logic [36:0]           vn_ext;
   logic [36:0]           x_u;
   logic [36:0]           xabs;
   logic [36:0]           zhi;
   logic [60:0]           zlo;
   logic [7:0]            whole;
   logic [29:0]           zfrac;
   logic [30:0]           f_v;
   logic [9:0]            k_v;
   logic [59:0]           gprod;
   logic [63:0]           pprod;
   logic [65:0]           wide;
   logic [9:0]            nk;
   logic [33:0]           rsh;
   logic [31:0]           newp;
   logic [32:0]           target;
   logic [32:0]           next_cnt;
   term_req_type          ereq;
   logic [34:0]           eq;
   logic                  edone;

   dbps_term u_exp_term (
      .clock (clock),
      .reset (reset),
      .req   (ereq),
      .quot  (eq),
      .done  (edone)
   );

   always_comb begin
      nabs      = norm_ff[32] ? 33'(-norm_ff) : 33'(norm_ff);
      vprod     = 63'(cfg.vol_per_step) * 63'(nabs[31:0]);
      drift_ext = {{5{cfg.drift_per_step[31]}}, cfg.drift_per_step};
      vn_ext    = {2'b0, vn_ff};
      x_u       = nneg_ff ? drift_ext - vn_ext : drift_ext + vn_ext;
      xabs      = x_u[36] ? -x_u : x_u;
      zhi       = 37'(xabs[35:30]) * 37'(LOG2E_Q30);
      zlo       = 61'(xabs[29:0]) * 61'(LOG2E_Q30);
      whole     = zm_ff[37:30];
      zfrac     = zm_ff[29:0];
      if (!xneg_ff) begin
         k_v = {2'b0, whole};
         f_v = {1'b0, zfrac};
      end else if (zfrac == '0) begin
         k_v = -{2'b0, whole};
         f_v = '0;
      end else begin
         k_v = -({2'b0, whole} + 10'd1);
         f_v = 31'(ONE_Q30) - {1'b0, zfrac};
      end
      gprod = 60'(f_v[29:0]) * 60'(LN2_Q30);
      pprod = 64'(price_ff) * 64'(sum_ff);

      wide = 66'(p_ff) << k_ff[4:0];
      nk   = -k_ff;
      rsh  = p_ff >> nk[5:0];
      if (!k_ff[9]) begin
         if (k_ff >= 10'd32) begin
            newp = (p_ff != '0) ? MAX32 : '0;
         end else if (wide[65:32] != '0) begin
            newp = MAX32;
         end else begin
            newp = wide[31:0];
         end
      end else begin
         if (nk >= 10'd64) begin
            newp = '0;
         end else if (rsh[33:32] != 2'b0) begin
            newp = MAX32;
         end else begin
            newp = rsh[31:0];
         end
      end

      target = {17'b0, cfg.pairs_per_path};
      if (target > COUNT_MAX) begin
         target = COUNT_MAX;
      end
      if (target == '0) begin
         target = 33'd1;
      end
      next_cnt = 33'(count_ff) + 33'd1;

      ereq.start = (state_ff == B_ETERM);
      ereq.t     = term_ff;
      ereq.m     = {2'b0, g_ff};
      ereq.d     = EXP_DIV[ek_ff];
      ereq.rcp   = EXP_RCP[ek_ff];
   end

   always_comb begin
      state_in     = state_ff;
      norm_in      = norm_ff;
      n1_in        = n1_ff;
      second_in    = second_ff;
      price_in     = price_ff;
      knock_in     = knock_ff;
      count_in     = count_ff;
      vn_in        = vn_ff;
      nneg_in      = nneg_ff;
      xneg_in      = xneg_ff;
      zm_in        = zm_ff;
      k_in         = k_ff;
      g_in         = g_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      ek_in        = ek_ff;
      p_in         = p_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      payoff_in    = payoff_ff;
      ko_in        = ko_ff;
      final_in     = final_ff;
      pop          = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (pair_valid) begin
               pop       = 1'b1;
               norm_in   = pair.n0;
               n1_in     = pair.n1;
               second_in = 1'b0;
               if (count_ff == '0) begin
                  price_in = cfg.start_price;
               end
               state_in = B_VN;
            end
         end
         B_VN: begin
            vn_in    = vprod[62:28];
            nneg_in  = norm_ff[32];
            state_in = B_X;
         end
         B_X: begin
            xneg_in  = x_u[36];
            zm_in    = 38'(zhi) + 38'(zlo[60:30]);
            state_in = B_G;
         end
         B_G: begin
            k_in     = k_v;
            g_in     = gprod[59:30];
            term_in  = ONE_Q30;
            sum_in   = ONE_Q30[31:0];
            ek_in    = '0;
            state_in = B_ETERM;
         end
         B_ETERM: begin
            state_in = B_EWAIT;
         end
         B_EWAIT: begin
            if (edone) begin
               term_in = eq[32:0];
               sum_in  = sum_ff + eq[31:0];
               if (ek_ff == 4'(EXP_TERMS - 1)) begin
                  state_in = B_MUL;
               end else begin
                  ek_in    = ek_ff + 4'd1;
                  state_in = B_ETERM;
               end
            end
         end
         B_MUL: begin
            p_in     = pprod[63:30];
            state_in = B_SHIFT;
         end
         B_SHIFT: begin
            price_in = newp;
            if (newp < cfg.lower_barrier || newp > cfg.upper_barrier) begin
               knock_in = 1'b1;
            end
            if (!second_ff) begin
               second_in = 1'b1;
               norm_in   = n1_ff;
               state_in  = B_VN;
            end else begin
               state_in = B_END;
            end
         end
         B_END: begin
            if (next_cnt < target) begin
               count_in = next_cnt[COUNT_BITS-1:0];
               state_in = B_IDLE;
            end else if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               payoff_in    = (!knock_ff && price_ff > cfg.strike_price) ?
                              price_ff - cfg.strike_price : '0;
               ko_in        = knock_ff;
               final_in     = price_ff;
               knock_in     = 1'b0;
               count_in     = '0;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         knock_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         knock_ff     <= knock_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      norm_ff   <= norm_in;
      n1_ff     <= n1_in;
      second_ff <= second_in;
      price_ff  <= price_in;
      vn_ff     <= vn_in;
      nneg_ff   <= nneg_in;
      xneg_ff   <= xneg_in;
      zm_ff     <= zm_in;
      k_ff      <= k_in;
      g_ff      <= g_in;
      term_ff   <= term_in;
      sum_ff    <= sum_in;
      ek_ff     <= ek_in;
      p_ff      <= p_in;
      payoff_ff <= payoff_in;
      ko_ff     <= ko_in;
      final_ff  <= final_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.payoff      = payoff_ff;
   assign rsp_ch.knocked_out = ko_ff;
   assign rsp_ch.final_price = final_ff;

endmodule

@@ src/double_barrier_path_step.sv @@
// Channel   Direction  Word
// req_ch    in         uniform_a, uniform_b: one pair of uniform samples
// rsp_ch    out        payoff, knocked_out, final_price: one word per finished path
// csr_      in         write enable, register index, write data
//
// The front stage works through the logarithm, square root and sine/cosine series
// for each word, and the back stage through two price steps per word,
// each dominated by sixteen exponential series terms through one shared term unit.
// The back stage sets the sustained rate.
// Reset is synchronous and active high; it restores the control and configuration registers.
// A two-word queue lets the front accept new words while the back stage or a
// stalled result word holds.
module double_barrier_path_step import dbps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   dbps_req_if.sink              req_ch,
   dbps_rsp_if.source            rsp_ch,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   pair_type push_pair, pop_pair;
   logic     push, full, pop, not_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_START_PRICE:    cfg_in.start_price    = csr_wdata;
            CSR_STRIKE_PRICE:   cfg_in.strike_price   = csr_wdata;
            CSR_UPPER_BARRIER:  cfg_in.upper_barrier  = csr_wdata;
            CSR_LOWER_BARRIER:  cfg_in.lower_barrier  = csr_wdata;
            CSR_DRIFT_PER_STEP: cfg_in.drift_per_step = csr_wdata;
            CSR_VOL_PER_STEP:   cfg_in.vol_per_step   = csr_wdata[30:0];
            CSR_PAIRS_PER_PATH: cfg_in.pairs_per_path = csr_wdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dbps_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .pair   (push_pair),
      .push   (push),
      .full   (full)
   );

   dbps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_pair),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_pair),
      .not_empty (not_empty)
   );

   dbps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pair       (pop_pair),
      .pair_valid (not_empty),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule
